// ===== rtl/core/dra_pkg.sv =====
// ----------------------------------------------------------------------------
// dra_pkg
// Types and constants shared by the dirty rectangle accumulator.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COMPACT       = 2'd2;
  localparam logic [1:0] CFG_FULL_REDRAW   = 2'd3;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
  } box_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic               last;
    logic signed [15:0] flush_left;
    logic signed [15:0] flush_top;
    logic signed [15:0] flush_right;
    logic signed [15:0] flush_bottom;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_PAREA,
    S_RD,
    S_CHK,
    S_MUL,
    S_CMP,
    S_APPEND,
    C_RDA,
    C_LA,
    C_RDB,
    C_WM,
    C_SR,
    C_SW,
    D_START,
    D_EM
  } state_t;

endpackage

// ===== rtl/core/dirty_rect_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_accumulator_top
// Dirty rectangle table with clip, merge on add and drain with bounding box.
//
// An item is taken when start is high and busy is low. An add clips the rect
// to the screen, scans the table entry by entry and merges, appends, or on
// overflow collapses the table to the screen rect. It produces no result and
// drops a rect that clips empty or that an entry holds. The single table
// memory has a registered read. A drain optionally compacts the table
// (pairwise scan, later entries shifted down over a merged one), then emits
// one entry per cycle on strobe/result, the flush box on the last one, and
// clears the table. A full-redraw drain of a non-empty table emits one
// screen rect. Results show for exactly one cycle; the receiver cannot
// stall them. Configuration is written on cfg_write; the user must write it
// only while idle, the block itself does not enforce this. Reset clears the
// entry count and loads the register defaults; table memory is not cleared.
// ----------------------------------------------------------------------------
module dirty_rect_accumulator_top
  import dra_pkg::*;
#(
  parameter int CAPACITY = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        strobe,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [15:0] screen_width, screen_height;
  logic        compact_before_drain, full_redraw;

  box_t mem [CAPACITY];
  box_t rdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  box_t          wdata;

  logic [CW-1:0] count, i, j, k;
  logic [CW-1:0] kp1;
  box_t          p, e, jn, f;
  logic [33:0]   area_p, area_e, area_j;
  logic          drain_mode;

  box_t scr, clip, jn_c, f_c;
  logic [16:0] wc, hc;
  logic clip_empty, hit_in, hit_ov, smaller;

  function automatic logic [33:0] area_of(box_t bx);
    logic signed [17:0] w;
    logic signed [17:0] h;
    w = {{2{bx.r[15]}}, bx.r} - {{2{bx.l[15]}}, bx.l} + 18'sd1;
    h = {{2{bx.b[15]}}, bx.b} - {{2{bx.t[15]}}, bx.t} + 18'sd1;
    if (w <= 18'sd0 || h <= 18'sd0) begin
      return 34'd0;
    end
    return w[16:0] * h[16:0];
  endfunction

  function automatic box_t join_of(box_t a, box_t c);
    box_t o;
    o.l = (a.l < c.l) ? a.l : c.l;
    o.t = (a.t < c.t) ? a.t : c.t;
    o.r = (a.r > c.r) ? a.r : c.r;
    o.b = (a.b > c.b) ? a.b : c.b;
    return o;
  endfunction

  always_comb begin
    wc = (screen_width > 16'h8000) ? 17'h08000 : {1'b0, screen_width};
    hc = (screen_height > 16'h8000) ? 17'h08000 : {1'b0, screen_height};
    scr.l = 16'sd0;
    scr.t = 16'sd0;
    scr.r = 16'(wc - 17'd1);
    scr.b = 16'(hc - 17'd1);
    clip.l = (p.l > 16'sd0) ? p.l : 16'sd0;
    clip.t = (p.t > 16'sd0) ? p.t : 16'sd0;
    clip.r = (p.r < scr.r) ? p.r : scr.r;
    clip.b = (p.b < scr.b) ? p.b : scr.b;
    clip_empty = (clip.l > clip.r) || (clip.t > clip.b);
    hit_in = (rdata.l <= p.l) && (rdata.r >= p.r) && (rdata.t <= p.t) && (rdata.b >= p.b);
    hit_ov = (rdata.l <= p.r) && (rdata.r >= p.l) && (rdata.t <= p.b) && (rdata.b >= p.t);
    jn_c = join_of(rdata, p);
    smaller = {1'b0, area_j} < ({1'b0, area_e} + {1'b0, area_p});
    kp1 = k + 1'b1;
    f_c = (k == '0) ? rdata : join_of(f, rdata);
  end

  always_comb begin
    state_next = state;
    raddr = i[AW-1:0];
    we = 1'b0;
    waddr = i[AW-1:0];
    wdata = jn;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (item.kind == KIND_ADD) begin
            state_next = S_CLIP;
          end else if (compact_before_drain) begin
            state_next = C_RDA;
          end else begin
            state_next = D_START;
          end
        end
      end
      S_CLIP: state_next = clip_empty ? S_IDLE : S_PAREA;
      S_PAREA: state_next = drain_mode ? C_RDB : S_RD;
      S_RD: begin
        state_next = (i >= count) ? S_APPEND : S_CHK;
      end
      S_CHK: begin
        if (!drain_mode && hit_in) begin
          state_next = S_IDLE;
        end else if (hit_ov) begin
          state_next = S_MUL;
        end else begin
          state_next = drain_mode ? C_RDB : S_RD;
        end
      end
      S_MUL: state_next = S_CMP;
      S_CMP: begin
        if (smaller) begin
          if (drain_mode) begin
            state_next = C_WM;
          end else begin
            we = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = drain_mode ? C_RDB : S_RD;
        end
      end
      S_APPEND: begin
        we = 1'b1;
        if (count < CW'(CAPACITY)) begin
          waddr = count[AW-1:0];
          wdata = p;
        end else begin
          waddr = '0;
          wdata = scr;
        end
        state_next = S_IDLE;
      end
      C_RDA: state_next = (i >= count) ? D_START : C_LA;
      C_LA: state_next = S_PAREA;
      C_RDB: begin
        raddr = j[AW-1:0];
        if (j == i) begin
          state_next = C_RDB;
        end else if (j >= count) begin
          state_next = C_RDA;
        end else begin
          state_next = S_CHK;
        end
      end
      C_WM: begin
        we = 1'b1;
        waddr = j[AW-1:0];
        state_next = C_SR;
      end
      C_SR: begin
        raddr = kp1[AW-1:0];
        state_next = (kp1 >= count) ? C_RDA : C_SW;
      end
      C_SW: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
        state_next = C_SR;
      end
      D_START: begin
        raddr = '0;
        if (count == '0 || full_redraw) begin
          state_next = S_IDLE;
        end else begin
          state_next = D_EM;
        end
      end
      D_EM: begin
        raddr = kp1[AW-1:0];
        state_next = (kp1 == count) ? S_IDLE : D_EM;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 16'd480;
      screen_height <= 16'd480;
      compact_before_drain <= 1'b0;
      full_redraw <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH: screen_width <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        CFG_COMPACT: compact_before_drain <= cfg_data[0];
        CFG_FULL_REDRAW: full_redraw <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_APPEND: count <= (count < CW'(CAPACITY)) ? count + 1'b1 : CW'(1);
        C_SR: begin
          if (kp1 >= count) begin
            count <= count - 1'b1;
          end
        end
        D_START: begin
          if (count != '0 && full_redraw) begin
            strobe <= 1'b1;
            count <= '0;
          end
        end
        D_EM: begin
          strobe <= 1'b1;
          if (kp1 == count) begin
            count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        p <= '{item.rect_left, item.rect_top, item.rect_right, item.rect_bottom};
        drain_mode <= item.kind;
        i <= '0;
        j <= '0;
      end
      S_CLIP: p <= clip;
      S_PAREA: begin
        area_p <= area_of(p);
        j <= '0;
      end
      S_CHK: begin
        e <= rdata;
        jn <= jn_c;
        if (!hit_ov) begin
          if (drain_mode) begin
            j <= j + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
      end
      S_MUL: begin
        area_e <= area_of(e);
        area_j <= area_of(jn);
      end
      S_CMP: begin
        if (!smaller) begin
          if (drain_mode) begin
            j <= j + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
      end
      C_LA: p <= rdata;
      C_RDB: begin
        if (j == i) begin
          j <= j + 1'b1;
        end else if (j >= count) begin
          i <= i + 1'b1;
        end
      end
      C_WM: k <= i;
      C_SW: k <= kp1;
      D_START: begin
        k <= '0;
        result.out_left <= scr.l;
        result.out_top <= scr.t;
        result.out_right <= scr.r;
        result.out_bottom <= scr.b;
        result.last <= 1'b1;
        result.flush_left <= scr.l;
        result.flush_top <= scr.t;
        result.flush_right <= scr.r;
        result.flush_bottom <= scr.b;
      end
      D_EM: begin
        k <= kp1;
        f <= f_c;
        result.out_left <= rdata.l;
        result.out_top <= rdata.t;
        result.out_right <= rdata.r;
        result.out_bottom <= rdata.b;
        result.last <= (kp1 == count);
        result.flush_left <= (kp1 == count) ? f_c.l : 16'sd0;
        result.flush_top <= (kp1 == count) ? f_c.t : 16'sd0;
        result.flush_right <= (kp1 == count) ? f_c.r : 16'sd0;
        result.flush_bottom <= (kp1 == count) ? f_c.b : 16'sd0;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/dra_checker.sv =====
// ----------------------------------------------------------------------------
// dra_checker
// Port-level checks for the dirty rectangle accumulator, bound to the top.
// ----------------------------------------------------------------------------
module dra_checker
  import dra_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("drain burst broken before last");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("block idle inside a drain burst");

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transaction accepted without going busy");

  a_flush: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.flush_left == 16'sd0 && result.flush_top == 16'sd0
      && result.flush_right == 16'sd0 && result.flush_bottom == 16'sd0)
    else $error("flush box off the last result");

  a_reset: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("activity right after reset");

endmodule

bind dirty_rect_accumulator_top dra_checker u_dra_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .strobe(strobe),
  .result(result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dirty rectangle accumulator. A behavioral model
// of the table (clip, merge, append, overflow, compaction, drain) predicts
// every drained rect and flush box; a scoreboard compares each strobed result
// in full against the prediction. Directed corner items run first, then random
// phases under several screen and mode settings with bursty input timing.
// ----------------------------------------------------------------------------
module tb_top;
  import dra_pkg::*;

  localparam int CAP = 24;
  localparam longint CYCLE_LIMIT = 2000000;

  class dirty_scoreboard;
    box_t    tbl[CAP];
    int      count;
    int      width, height;
    bit      compact_on, full_on;
    result_t drained_q[$];
    int      errors;
    int      checked;

    function new();
      count = 0;
      width = 480;
      height = 480;
      compact_on = 0;
      full_on = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SCREEN_WIDTH:  width = val;
        CFG_SCREEN_HEIGHT: height = val;
        CFG_COMPACT:       compact_on = val[0];
        CFG_FULL_REDRAW:   full_on = val[0];
        default: ;
      endcase
    endfunction

    function box_t screen();
      box_t s;
      int w, h;
      w = width > 32768 ? 32768 : width;
      h = height > 32768 ? 32768 : height;
      s.l = 0;
      s.t = 0;
      s.r = 16'(w - 1);
      s.b = 16'(h - 1);
      return s;
    endfunction

    function longint area(box_t a);
      longint w, h;
      w = longint'(a.r) - longint'(a.l) + 1;
      h = longint'(a.b) - longint'(a.t) + 1;
      if (w <= 0 || h <= 0) return 0;
      return w * h;
    endfunction

    function bit holds(box_t a, box_t b);
      return a.l <= b.l && a.r >= b.r && a.t <= b.t && a.b >= b.b;
    endfunction

    function bit touches(box_t a, box_t b);
      return a.l <= b.r && a.r >= b.l && a.t <= b.b && a.b >= b.t;
    endfunction

    function box_t bound(box_t a, box_t b);
      box_t j;
      j.l = a.l < b.l ? a.l : b.l;
      j.t = a.t < b.t ? a.t : b.t;
      j.r = a.r > b.r ? a.r : b.r;
      j.b = a.b > b.b ? a.b : b.b;
      return j;
    endfunction

    function void add_rect(box_t in);
      box_t s, c, j;
      s = screen();
      c.l = in.l > s.l ? in.l : s.l;
      c.t = in.t > s.t ? in.t : s.t;
      c.r = in.r < s.r ? in.r : s.r;
      c.b = in.b < s.b ? in.b : s.b;
      if (c.l > c.r || c.t > c.b) return;
      for (int i = 0; i < count; i++) begin
        if (holds(tbl[i], c)) return;
        if (touches(tbl[i], c)) begin
          j = bound(tbl[i], c);
          if (area(j) < area(tbl[i]) + area(c)) begin
            tbl[i] = j;
            return;
          end
        end
      end
      if (count < CAP) begin
        tbl[count] = c;
        count++;
      end else begin
        tbl[0] = s;
        count = 1;
      end
    endfunction

    function void compact_table();
      int i;
      bit merged;
      box_t m;
      i = 0;
      while (i < count) begin
        merged = 0;
        for (int j = 0; j < count; j++) begin
          if (j == i) continue;
          if (!touches(tbl[j], tbl[i])) continue;
          m = bound(tbl[i], tbl[j]);
          if (area(m) < area(tbl[i]) + area(tbl[j])) begin
            tbl[j] = m;
            for (int k = i; k + 1 < count; k++) tbl[k] = tbl[k + 1];
            count--;
            merged = 1;
            break;
          end
        end
        if (!merged) i++;
      end
    endfunction

    function result_t make(box_t r, bit lst, box_t f);
      result_t o;
      o = '0;
      o.out_left = r.l;
      o.out_top = r.t;
      o.out_right = r.r;
      o.out_bottom = r.b;
      o.last = lst;
      if (lst) begin
        o.flush_left = f.l;
        o.flush_top = f.t;
        o.flush_right = f.r;
        o.flush_bottom = f.b;
      end
      return o;
    endfunction

    function void note_item(item_t it);
      box_t r, f;
      int n;
      if (it.kind == KIND_ADD) begin
        r.l = it.rect_left;
        r.t = it.rect_top;
        r.r = it.rect_right;
        r.b = it.rect_bottom;
        add_rect(r);
        return;
      end
      if (compact_on) compact_table();
      n = count;
      count = 0;
      if (n == 0) return;
      if (full_on) begin
        drained_q.push_back(make(screen(), 1, screen()));
        return;
      end
      f = tbl[0];
      for (int k = 0; k < n; k++) f = bound(f, tbl[k]);
      for (int k = 0; k < n; k++) drained_q.push_back(make(tbl[k], k == n - 1, f));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      checked++;
      if (drained_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = drained_q.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  item_t       item = '0;
  logic        strobe;
  result_t     result;
  logic        cfg_write = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dirty_scoreboard sb;
  longint cycles = 0;
  int items_sent = 0;

  dirty_rect_accumulator_top #(.CAPACITY(CAP)) i_dut (
    .clk, .rst, .start, .busy, .item, .strobe, .result,
    .cfg_write, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(result);
  end

  // hold the write until the block is idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    while (busy) @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // hold start until the transaction is taken
  task automatic send(item_t it);
    @(negedge clk);
    start <= 1;
    item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
    start <= 0;
    item <= '0;
  endtask

  task automatic send_add(int l, int t, int r, int b);
    item_t it;
    it.kind = KIND_ADD;
    it.rect_left = 16'(l);
    it.rect_top = 16'(t);
    it.rect_right = 16'(r);
    it.rect_bottom = 16'(b);
    send(it);
  endtask

  task automatic send_drain();
    item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[64:0];
    it.kind = KIND_DRAIN;
    send(it);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    while (sb.drained_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic int coord(int span);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535) - 32768;
      1: return -$urandom_range(1, 20);
      2: return span + $urandom_range(0, 20);
      default: return $urandom_range(0, span > 0 ? span : 1);
    endcase
  endfunction

  task automatic random_phase(int n, int w, int h, bit cmp, bit full);
    int gap, burst, l, t, sz;
    write_reg(CFG_SCREEN_WIDTH, 16'(w));
    write_reg(CFG_SCREEN_HEIGHT, 16'(h));
    write_reg(CFG_COMPACT, 16'(cmp));
    write_reg(CFG_FULL_REDRAW, 16'(full));
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end
      burst--;
      if ($urandom_range(0, 11) == 0) send_drain();
      else if ($urandom_range(0, 3) == 0) begin
        send_add(coord(w), coord(h), coord(w), coord(h));
      end else begin
        sz = $urandom_range(0, 3) == 0 ? 80 : 12;
        l = $urandom_range(0, w);
        t = $urandom_range(0, h);
        send_add(l, t, l + $urandom_range(0, sz), t + $urandom_range(0, sz));
      end
    end
    send_drain();
    settle();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_add(-32768, -32768, 32767, 32767);
    send_add(10, 10, 20, 20);
    send_drain();
    send_drain();
    send_add(5, 5, 1, 1);
    send_add(500, 0, 600, 10);
    send_add(0, 0, 3, 3);
    send_add(1, 1, 2, 2);
    send_add(2, 2, 6, 6);
    send_add(100, 100, 110, 110);
    send_add(-5, 470, 3, 32767);
    send_drain();
    settle();
    write_reg(CFG_FULL_REDRAW, 16'd1);
    send_add(7, 7, 9, 9);
    send_drain();
    send_drain();
    settle();
    write_reg(CFG_FULL_REDRAW, 16'd0);
    for (int k = 0; k < 25; k++) send_add(k * 15, 0, k * 15 + 3, 3);
    send_drain();
    settle();
    write_reg(CFG_SCREEN_WIDTH, 16'hFFFF);
    write_reg(CFG_SCREEN_HEIGHT, 16'hFFFF);
    send_add(32767, 32767, 32767, 32767);
    write_reg(CFG_SCREEN_WIDTH, 16'd0);
    send_add(0, 0, 5, 5);
    write_reg(CFG_FULL_REDRAW, 16'd1);
    send_drain();
    settle();

    random_phase(50, 480, 480, 0, 0);
    random_phase(50, 64, 48, 1, 0);
    random_phase(30, 1, 1, 0, 0);
    random_phase(30, 200, 120, 1, 1);
    random_phase(50, 40, 40, 1, 0);

    $display("Sent %0d items; checked %0d results", items_sent, sb.checked);
    $display("Covered clip, merge, overflow, compaction, full redraw, screen extremes");
    if (sb.errors == 0 && sb.drained_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== dirty_rect_accumulator_top.f =====
rtl/core/dra_pkg.sv
rtl/core/dirty_rect_accumulator_top.sv
rtl/core/dra_checker.sv
tb/sv/tb_top.sv
